### src/pmbm_pkg.sv
`default_nettype none
package pmbm_pkg;

   localparam int unsigned ADDR_W = 20;
   localparam int unsigned PAGE_W = 6;
   localparam int unsigned OFFS_W = 14;
   localparam int unsigned SLOT_W = 2;
   localparam int unsigned NUM_SLOTS = 4;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned OP_W = 2;
   localparam int unsigned PADDR_W = 4;
   localparam int unsigned PDATA_W = 32;
   localparam int unsigned REG_IDX_W = 2;

   // Transaction operation codes.
   localparam logic [OP_W-1:0] OP_MEM_READ = 2'd0;
   localparam logic [OP_W-1:0] OP_MEM_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_PAGE = 2'd2;
   localparam logic [OP_W-1:0] OP_SET_ENABLE = 2'd3;

   // Register indexes (byte address is 4 times the index).
   localparam logic [REG_IDX_W-1:0] REG_BANKED_MODE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_NARROW_MAP = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_RAM_START = 2'd2;

   localparam logic [ADDR_W-1:0] RAM_START_RESET = 20'h80000;

   typedef struct packed {
      logic              banked_mode;
      logic              narrow_map;
      logic [ADDR_W-1:0] ram_start;
   } cfg_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0][PAGE_W-1:0] slot_pages;
      logic                             banking_on;
   } bank_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] address;
      logic [SLOT_W-1:0] slot_index;
      logic [DATA_W-1:0] data;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] mapped_address;
      logic              write_strobe;
      logic              rom_write_blocked;
   } rsp_type;

endpackage
`default_nettype wire

### src/pmbm_if.sv
`default_nettype none
interface pmbm_req_if;
   logic                               valid;
   logic                               ready;
   logic [pmbm_pkg::OP_W-1:0]   operation;
   logic [pmbm_pkg::ADDR_W-1:0] address;
   logic [pmbm_pkg::SLOT_W-1:0] slot_index;
   logic [pmbm_pkg::DATA_W-1:0] data;

   modport source (output valid, operation, address, slot_index, data, input ready);
   modport sink (input valid, operation, address, slot_index, data, output ready);
endinterface

interface pmbm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pmbm_pkg::ADDR_W-1:0] mapped_address;
   logic                               write_strobe;
   logic                               rom_write_blocked;

   modport source (output valid, mapped_address, write_strobe, rom_write_blocked,
                   input ready);
   modport sink (input valid, mapped_address, write_strobe, rom_write_blocked,
                 output ready);
endinterface
`default_nettype wire

### src/paged_memory_bank_mapper.sv
`default_nettype none
// Channel   Port             Direction  Moves
// request   req_chan         in         operation, address, slot_index, data
// response  rsp_chan         out        mapped_address, write_strobe, rom_write_blocked
// config    psel..prdata     in/out     banked_mode, narrow_map, ram_start
//
// One transaction is accepted per cycle while the response side does not stall;
// it passes through the input register and then the response register.
// Reset clears both valid flags, the slot pages, the banking enable and the
// configuration registers (ram_start returns to 0x80000).
// A stalled response holds in its register; the input register still takes a
// new transaction whenever its content moves on in the same cycle.
module paged_memory_bank_mapper (
   input  wire logic                               clock,
   input  wire logic                               reset,
   pmbm_req_if.sink                                req_chan,
   pmbm_rsp_if.source                              rsp_chan,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [pmbm_pkg::PADDR_W-1:0] paddr,
   input  wire logic [pmbm_pkg::PDATA_W-1:0] pwdata,
   output logic      [pmbm_pkg::PDATA_W-1:0] prdata,
   output logic                                    pready
);

   pmbm_pkg::cfg_type  cfg;
   pmbm_pkg::bank_type bank;
   pmbm_pkg::req_type  req_ff;
   pmbm_pkg::req_type  req_in;
   pmbm_pkg::rsp_type  rsp_ff;
   pmbm_pkg::rsp_type  rsp_in;
   logic req_valid_ff;
   logic req_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic advance;
   logic req_take;

   pmbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The held transaction moves into the response register when that register
   // is empty or being drained. Bank state updates at the same edge, so the
   // next transaction in the input register already sees it.
   assign advance = req_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~req_valid_ff | advance;
   assign req_take = req_chan.valid & req_chan.ready;

   pmbm_bank_regs u_bank_regs (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .req         (req_ff),
      .banked_mode (cfg.banked_mode),
      .bank        (bank)
   );

   pmbm_xlate u_xlate (
      .req  (req_ff),
      .cfg  (cfg),
      .bank (bank),
      .rsp  (rsp_in)
   );

   always_comb begin
      req_in.operation = req_chan.operation;
      req_in.address = req_chan.address;
      req_in.slot_index = req_chan.slot_index;
      req_in.data = req_chan.data;
      req_valid_in = req_take | (req_valid_ff & ~advance);
      rsp_valid_in = advance | (rsp_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.mapped_address = rsp_ff.mapped_address;
   assign rsp_chan.write_strobe = rsp_ff.write_strobe;
   assign rsp_chan.rom_write_blocked = rsp_ff.rom_write_blocked;

endmodule
`default_nettype wire

### src/pmbm_csr.sv
`default_nettype none
module pmbm_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [pmbm_pkg::PADDR_W-1:0] paddr,
   input  wire logic [pmbm_pkg::PDATA_W-1:0] pwdata,
   output logic      [pmbm_pkg::PDATA_W-1:0] prdata,
   output logic                                    pready,
   output pmbm_pkg::cfg_type                       cfg
);

   pmbm_pkg::cfg_type cfg_ff;
   pmbm_pkg::cfg_type cfg_in;
   logic [pmbm_pkg::REG_IDX_W-1:0] reg_idx;
   logic write_en;

   assign pready = 1'b1;
   assign reg_idx = paddr[pmbm_pkg::PADDR_W-1:2];
   assign write_en = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_idx)
            pmbm_pkg::REG_BANKED_MODE: cfg_in.banked_mode = pwdata[0];
            pmbm_pkg::REG_NARROW_MAP: cfg_in.narrow_map = pwdata[0];
            pmbm_pkg::REG_RAM_START: cfg_in.ram_start = pwdata[pmbm_pkg::ADDR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.banked_mode <= 1'b0;
         cfg_ff.narrow_map <= 1'b0;
         cfg_ff.ram_start <= pmbm_pkg::RAM_START_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         pmbm_pkg::REG_BANKED_MODE: prdata = {31'd0, cfg_ff.banked_mode};
         pmbm_pkg::REG_NARROW_MAP: prdata = {31'd0, cfg_ff.narrow_map};
         pmbm_pkg::REG_RAM_START: prdata = {12'd0, cfg_ff.ram_start};
         default: prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### src/pmbm_bank_regs.sv
`default_nettype none
module pmbm_bank_regs (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                update,
   input  wire pmbm_pkg::req_type   req,
   input  wire logic                banked_mode,
   output pmbm_pkg::bank_type       bank
);

   pmbm_pkg::bank_type bank_ff;
   pmbm_pkg::bank_type bank_in;

   // Page and enable writes only reach the card when it is fitted.
   always_comb begin
      bank_in = bank_ff;
      if (update && banked_mode) begin
         case (req.operation)
            pmbm_pkg::OP_SET_PAGE:
               bank_in.slot_pages[req.slot_index] = req.data[pmbm_pkg::PAGE_W-1:0];
            pmbm_pkg::OP_SET_ENABLE: bank_in.banking_on = req.data[0];
            default: bank_in = bank_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= '0;
      end else begin
         bank_ff <= bank_in;
      end
   end

   assign bank = bank_ff;

endmodule
`default_nettype wire

### src/pmbm_xlate.sv
`default_nettype none
module pmbm_xlate (
   input  wire pmbm_pkg::req_type  req,
   input  wire pmbm_pkg::cfg_type  cfg,
   input  wire pmbm_pkg::bank_type bank,
   output pmbm_pkg::rsp_type       rsp
);

   logic [pmbm_pkg::ADDR_W-1:0] addr_bank;
   logic [pmbm_pkg::ADDR_W-1:0] addr_map;
   logic is_mem;
   logic is_write;
   logic in_ram;

   always_comb begin
      addr_bank = req.address;
      if (cfg.banked_mode) begin
         addr_bank = {4'd0, req.address[15:0]};
         if (bank.banking_on) begin
            addr_bank = {bank.slot_pages[req.address[15:14]],
                         req.address[pmbm_pkg::OFFS_W-1:0]};
         end
      end
      addr_map = addr_bank;
      if (cfg.narrow_map) begin
         // Keep 19 bits; the upper 256K holds a 128K RAM seen twice.
         addr_map[19] = 1'b0;
         if (addr_bank[18]) begin
            addr_map[17] = 1'b0;
         end
      end
   end

   assign is_mem = (req.operation == pmbm_pkg::OP_MEM_READ) ||
                   (req.operation == pmbm_pkg::OP_MEM_WRITE);
   assign is_write = (req.operation == pmbm_pkg::OP_MEM_WRITE);
   assign in_ram = (addr_map >= cfg.ram_start);

   assign rsp.mapped_address = is_mem ? addr_map : '0;
   assign rsp.write_strobe = is_write & in_ram;
   assign rsp.rom_write_blocked = is_write & ~in_ram;

endmodule
`default_nettype wire

### sim/paged_memory_bank_mapper_tb.sv
`default_nettype none
module paged_memory_bank_mapper_tb;
   import pmbm_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   // Extra margin for the input register and the response register to empty.
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned MAX_WAIT = 13;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned ITEMS_PER_PHASE = 228;
   localparam int unsigned MAX_REPORTS = 40;
   // Decodes to no register; a write there must change nothing.
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   pmbm_req_if req_chan();
   pmbm_rsp_if rsp_chan();

   // Shadow copy of the configuration and the bank card state.
   cfg_type  cfg_now;
   bank_type bank_now;
   rsp_type  expected_rsps[$];
   int unsigned error_count = 0;
   bit quiet_sender = 1'b0;
   bit quiet_receiver = 1'b0;

   paged_memory_bank_mapper DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #4 clock = ~clock;

   // Address translation as the bank card and the narrow map see it.
   function automatic logic [ADDR_W-1:0] translate_address(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] m;
      logic [SLOT_W-1:0] slot;
      m = a;
      if (cfg_now.banked_mode) begin
         m = {4'h0, m[15:0]};
         if (bank_now.banking_on) begin
            slot = m[15:14];
            m = {bank_now.slot_pages[slot], m[OFFS_W-1:0]};
         end
      end
      if (cfg_now.narrow_map) begin
         m[19] = 1'b0;
         // The upper 256K holds a 128K RAM that appears twice.
         if (m[18]) m[17] = 1'b0;
      end
      return m;
   endfunction

   // Works out the response to one transaction and updates the bank state.
   function automatic rsp_type map_request(input req_type r);
      rsp_type o;
      o = '0;
      case (r.operation)
         OP_MEM_READ: begin
            o.mapped_address = translate_address(r.address);
         end
         OP_MEM_WRITE: begin
            o.mapped_address = translate_address(r.address);
            if (o.mapped_address >= cfg_now.ram_start) o.write_strobe = 1'b1;
            else o.rom_write_blocked = 1'b1;
         end
         OP_SET_PAGE: begin
            if (cfg_now.banked_mode) bank_now.slot_pages[r.slot_index] = r.data[PAGE_W-1:0];
         end
         default: begin
            if (cfg_now.banked_mode) bank_now.banking_on = r.data[0];
         end
      endcase
      return o;
   endfunction

   function automatic req_type make_req(input logic [OP_W-1:0] op,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [DATA_W-1:0] value);
      req_type r;
      r.operation = op;
      r.address = addr;
      r.slot_index = slot;
      r.data = value;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] random_address();
      logic [ADDR_W-1:0] a;
      case ($urandom_range(0, 4))
         0: a = cfg_now.ram_start - 20'd2 + 20'($urandom_range(0, 4));
         1: a = $urandom_range(0, 1) ? 20'h00000 : 20'hFFFFF;
         default: a = 20'($urandom_range(0, 20'hFFFFF));
      endcase
      return a;
   endfunction

   function automatic req_type random_request();
      int unsigned pick;
      logic [OP_W-1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_MEM_READ;
      else if (pick < 80) op = OP_MEM_WRITE;
      else if (pick < 90) op = OP_SET_PAGE;
      else op = OP_SET_ENABLE;
      return make_req(op, random_address(), 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)));
   endfunction

   // Drives one transaction after a random gap (none when the sender is quiet) and records its expected response.
   task automatic send_request(input req_type item);
      int unsigned gap;
      gap = quiet_sender ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.operation <= item.operation;
      req_chan.address <= item.address;
      req_chan.slot_index <= item.slot_index;
      req_chan.data <= item.data;
      do @(posedge clock); while (!req_chan.ready);
      expected_rsps.push_back(map_request(item));
   endtask

   // Stops sending and waits until every response is back and the pipeline is empty.
   task automatic drain_responses();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                 input logic [PDATA_W-1:0] value);
      drain_responses();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_BANKED_MODE: cfg_now.banked_mode = value[0];
         REG_NARROW_MAP: cfg_now.narrow_map = value[0];
         REG_RAM_START: cfg_now.ram_start = value[ADDR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Reset configuration: no bank card, full 20-bit addresses, ROM below 512K.
   // Page and enable transactions must be ignored here.
   task automatic test_reset_passthrough();
      send_request(make_req(OP_MEM_READ, 20'h00000, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_READ, 20'hFFFFF, 2'd3, 8'hFF));
      send_request(make_req(OP_MEM_WRITE, 20'h7FFFF, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_WRITE, 20'h80000, 2'd0, 8'h00));
      send_request(make_req(OP_SET_PAGE, 20'h00000, 2'd3, 8'h3F));
      send_request(make_req(OP_SET_ENABLE, 20'h00000, 2'd0, 8'hFF));
      send_request(make_req(OP_MEM_WRITE, 20'hFFFFF, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_READ, 20'hFC000, 2'd0, 8'h00));
   endtask

   // Bank card present: first with banking off (16-bit cut), then each slot paged.
   task automatic test_banked_translation();
      write_register(REG_BANKED_MODE, 32'd1);
      send_request(make_req(OP_MEM_READ, 20'hFFFFF, 2'd0, 8'h00));
      send_request(make_req(OP_SET_PAGE, 20'h00000, 2'd0, 8'hFF));
      send_request(make_req(OP_SET_PAGE, 20'h00000, 2'd1, 8'h15));
      send_request(make_req(OP_SET_PAGE, 20'h00000, 2'd2, 8'h2A));
      send_request(make_req(OP_SET_PAGE, 20'h00000, 2'd3, 8'hC0));
      send_request(make_req(OP_SET_ENABLE, 20'h00000, 2'd0, 8'h01));
      send_request(make_req(OP_MEM_READ, 20'h03FFF, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_WRITE, 20'hF4000, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_READ, 20'h0BFFF, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_WRITE, 20'h0C000, 2'd0, 8'h00));
      send_request(make_req(OP_SET_ENABLE, 20'h00000, 2'd0, 8'hFE));
      send_request(make_req(OP_MEM_READ, 20'h1C123, 2'd0, 8'h00));
   endtask

   // Narrow map folds the upper 256K, checked with the card removed.
   task automatic test_narrow_map();
      write_register(REG_BANKED_MODE, 32'd0);
      write_register(REG_NARROW_MAP, 32'd1);
      send_request(make_req(OP_MEM_READ, 20'hFFFFF, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_READ, 20'h3FFFF, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_WRITE, 20'h60000, 2'd0, 8'h00));
      write_register(REG_RAM_START, 32'h40000);
      send_request(make_req(OP_MEM_WRITE, 20'hE0000, 2'd0, 8'h00));
   endtask

   // RAM start at both ends, a write exactly at the start, and an unmapped register.
   task automatic test_ram_start_limits();
      write_register(REG_NARROW_MAP, 32'd0);
      write_register(REG_RAM_START, 32'h00000);
      send_request(make_req(OP_MEM_WRITE, 20'h00000, 2'd0, 8'h00));
      write_register(REG_RAM_START, 32'hFFFFF);
      write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
      send_request(make_req(OP_MEM_WRITE, 20'hFFFFE, 2'd0, 8'h00));
      send_request(make_req(OP_MEM_WRITE, 20'hFFFFF, 2'd0, 8'h00));
   endtask

   // Every mode combination twice, with junk above each register's width.
   task automatic test_random_traffic();
      logic [ADDR_W-1:0] base;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 2) base = 20'h00000;
         else if (p == 5) base = 20'hFFFFF;
         else base = 20'($urandom_range(0, 20'hFFFFF));
         write_register(REG_BANKED_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(p % 2));
         write_register(REG_NARROW_MAP, ($urandom & 32'hFFFF_FFFE) | 32'((p / 2) % 2));
         write_register(REG_RAM_START, ($urandom & 32'hFFF0_0000) | 32'(base));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 50 == 0) begin
               quiet_sender = ($urandom_range(0, 3) == 0);
               quiet_receiver = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) == 0) drain_responses();
            send_request(random_request());
         end
      end
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;
   endtask

   // Response side: random stall (none when the receiver is quiet) before each transaction.
   initial begin : response_stalls
      int unsigned stall;
      forever begin
         stall = quiet_receiver ? 0 : $urandom_range(0, MAX_WAIT);
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] want,
                                  input logic [ADDR_W-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected response expected none actual %h", $time,
                        rsp_chan.mapped_address);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_chan.mapped_address !== want.mapped_address)
               report_mismatch("mapped_address", want.mapped_address, rsp_chan.mapped_address);
            if (rsp_chan.write_strobe !== want.write_strobe)
               report_mismatch("write_strobe", 20'(want.write_strobe),
                               20'(rsp_chan.write_strobe));
            if (rsp_chan.rom_write_blocked !== want.rom_write_blocked)
               report_mismatch("rom_write_blocked", 20'(want.rom_write_blocked),
                               20'(rsp_chan.rom_write_blocked));
         end
      end
   end

   // Ends the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      int unsigned idle_cycles;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_MEM_READ;
      req_chan.address = '0;
      req_chan.slot_index = '0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_now.banked_mode = 1'b0;
      cfg_now.narrow_map = 1'b0;
      cfg_now.ram_start = RAM_START_RESET;
      bank_now = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_passthrough();
      test_banked_translation();
      test_narrow_map();
      test_ram_start_limits();
      test_random_traffic();
      drain_responses();

      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
src/pmbm_pkg.sv
src/pmbm_if.sv
src/pmbm_csr.sv
src/pmbm_bank_regs.sv
src/pmbm_xlate.sv
src/paged_memory_bank_mapper.sv
sim/paged_memory_bank_mapper_tb.sv
